// File: rtl/qja_pkg.sv
package qja_pkg;

    typedef enum logic [1:0] {
        K_PUSH  = 2'd0,
        K_POP   = 2'd1,
        K_QUERY = 2'd2,
        K_JUMP  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOREF = 2'd3
    } t_status;

    typedef struct packed {
        logic load;    // capture the input beat and run the search
        logic commit;  // apply the operation to the cells and build the result
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_stat;

endpackage

// File: rtl/qja_ctrl.sv
module qja_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output qja_pkg::t_cmd  o_cmd
);
    import qja_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_OUT    = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                o_ready = i_ready;
                if (i_ready) begin
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SEARCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// File: rtl/qja_dp.sv
module qja_dp #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qja_pkg::t_cmd        i_cmd,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_value,
    input  logic [5:0]           i_handle,
    input  logic [15:0]          i_jump_distance,
    output logic [1:0]           o_status,
    output logic [31:0]          o_payload,
    output logic [5:0]           o_new_handle,
    output logic [5:0]           o_place,
    output logic [6:0]           o_entry_count
);
    import qja_pkg::*;

    localparam int HW = (DEPTH > 64) ? 64 : DEPTH;   // usable handles
    localparam int PW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    // order cells: handle at each place, shifted in parallel
    logic [5:0]            r_cell [DEPTH];
    logic [DATA_WIDTH-1:0] r_pay  [HW];
    logic [HW-1:0]         r_used;
    logic [PW-1:0]         r_occ;

    // captured beat and search results
    t_kind            r_kind;
    logic [DATA_WIDTH-1:0] r_value;
    logic [5:0]       r_h;
    logic [15:0]      r_dist;
    logic             r_hit;
    logic [IW-1:0]    r_pos;
    logic             r_free_ok;
    logic [5:0]       r_free;

    // search over cells (match compare, priority pick)
    logic          s_hit;
    logic [IW-1:0] s_pos;
    logic          s_free_ok;
    logic [5:0]    s_free;

    always_comb begin
        s_hit     = 1'b0;
        s_pos     = '0;
        s_free_ok = 1'b0;
        s_free    = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (PW'(i) < r_occ && r_cell[i] == i_handle) begin
                s_hit = 1'b1;
                s_pos = IW'(i);
            end
        end
        if (!(32'(i_handle) < HW && r_used[i_handle[IW > 6 ? 5 : IW-1:0]])) s_hit = 1'b0;
        for (int j = HW - 1; j >= 0; j--) begin
            if (!r_used[j]) begin
                s_free_ok = 1'b1;
                s_free    = 6'(j);
            end
        end
        if (r_occ == PW'(DEPTH)) s_free_ok = 1'b0;
    end

    logic [IW:0]   tgt_w;
    logic [IW-1:0] tgt;
    always_comb begin
        if ({1'b0, r_dist} > 17'(r_pos)) tgt_w = '0;
        else tgt_w = (IW+1)'(r_pos) - (IW+1)'(r_dist);
        tgt = tgt_w[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= t_kind'(i_kind);
            r_value   <= i_value[DATA_WIDTH > 32 ? 31 : DATA_WIDTH-1:0];
            r_h       <= i_handle;
            r_dist    <= i_jump_distance;
            r_hit     <= s_hit;
            r_pos     <= s_pos;
            r_free_ok <= s_free_ok;
            r_free    <= s_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_occ  <= '0;
        end else if (i_cmd.commit) begin
            case (r_kind)
                K_PUSH: if (r_free_ok) begin
                    r_used[r_free[IW > 6 ? 5 : IW-1:0]] <= 1'b1;
                    r_occ <= r_occ + 1'b1;
                end
                K_POP: if (r_occ != '0) begin
                    r_used[r_cell[0][IW > 6 ? 5 : IW-1:0]] <= 1'b0;
                    r_occ <= r_occ - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            case (r_kind)
                K_PUSH: if (r_free_ok) begin
                    r_pay[r_free[IW > 6 ? 5 : IW-1:0]] <= r_value;
                    r_cell[r_occ[IW-1:0]] <= r_free;
                end
                K_POP: if (r_occ != '0) begin
                    for (int i = 0; i < DEPTH - 1; i++) r_cell[i] <= r_cell[i+1];
                end
                K_JUMP: if (r_hit) begin
                    for (int i = 1; i < DEPTH; i++)
                        if (IW'(i) > tgt && IW'(i) <= r_pos) r_cell[i] <= r_cell[i-1];
                    r_cell[tgt] <= r_h;
                end
                default: ;
            endcase
        end
    end

    // result register, built from pre-commit state
    logic [PW-1:0] n_cnt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_status     <= ST_OK;
            o_payload    <= '0;
            o_new_handle <= '0;
            o_place      <= '0;
            case (r_kind)
                K_PUSH: if (r_free_ok) o_new_handle <= r_free;
                        else o_status <= ST_FULL;
                K_POP: if (r_occ != '0)
                           o_payload <= 32'(r_pay[r_cell[0][IW > 6 ? 5 : IW-1:0]]);
                       else o_status <= ST_EMPTY;
                K_QUERY: if (r_hit) o_place <= 6'(r_pos);
                         else o_status <= ST_NOREF;
                K_JUMP: if (r_hit) o_place <= 6'(tgt);
                        else o_status <= ST_NOREF;
                default: ;
            endcase
            o_entry_count <= 7'(n_cnt);
        end
    end

    always_comb begin
        n_cnt = r_occ;
        if (r_kind == K_PUSH && r_free_ok) n_cnt = r_occ + 1'b1;
        if (r_kind == K_POP && r_occ != '0) n_cnt = r_occ - 1'b1;
    end
endmodule

// File: rtl/queue_with_jump_ahead_unit.sv
// Ordered queue with jump-ahead by handle.
// Input channel (i_valid/o_ready) carries one operation per beat: push a value,
// pop the head, query a handle's place, or jump a handle's entry forward.
// Output channel (o_valid/i_ready) returns one result beat per operation with
// status, popped payload, new handle, place and the entry count afterwards.
// The result of an accepted beat is offered once the search state has registered it.
// The handle match and free-handle search run over the order cells while the
// beat is offered and are captured with it at the accepting edge; the next
// cycle shifts the cells and registers the result.
// A new beat is not accepted while the last one is still in progress; the next
// beat is accepted in the same cycle the result is taken.
// When the receiver stalls the result holds and no new beat is accepted.
// Reset (synchronous, active low) empties the queue and frees all handles;
// the cell and payload contents are left as they were.
module queue_with_jump_ahead_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_handle,
    input  logic [15:0] i_jump_distance,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_payload,
    output logic [5:0]  o_new_handle,
    output logic [5:0]  o_place,
    output logic [6:0]  o_entry_count
);
    import qja_pkg::*;

    t_cmd w_cmd;

    qja_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    qja_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_handle        (i_handle),
        .i_jump_distance (i_jump_distance),
        .o_status        (o_status),
        .o_payload       (o_payload),
        .o_new_handle    (o_new_handle),
        .o_place         (o_place),
        .o_entry_count   (o_entry_count)
    );
endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qja_pkg::*;

    localparam int QDEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    // One operation beat as offered to the block
    typedef struct {
        t_kind       kind;
        logic [31:0] value;
        logic [5:0]  handle;
        logic [15:0] jump_len;
    } op_t;

    // One result beat
    typedef struct {
        t_status     status;
        logic [31:0] payload;
        logic [5:0]  new_handle;
        logic [5:0]  place;
        logic [6:0]  count;
    } res_t;

    // Scoreboard: own copy of the queue, predicts each result on acceptance
    class queue_scoreboard;
        logic [5:0]  order[QDEPTH];
        logic [31:0] stored[QDEPTH];
        bit          busy[QDEPTH];
        int          occ;
        res_t        awaited[$];
        int          errors;
        int          n_checked;
        int          n_status[4];

        function void clear();
            occ = 0;
            foreach (busy[i]) busy[i] = 0;
            awaited.delete();
        endfunction

        function int place_of(logic [5:0] h);
            for (int i = 0; i < occ; i++)
                if (order[i] == h) return i;
            return -1;
        endfunction

        function void note_op(op_t op);
            res_t r;
            int   pos;
            int   tgt;
            r = '{ST_OK, 32'd0, 6'd0, 6'd0, 7'd0};
            case (op.kind)
                K_PUSH: begin
                    pos = -1;
                    if (occ < QDEPTH)
                        for (int i = 0; i < QDEPTH; i++)
                            if (!busy[i]) begin
                                pos = i;
                                break;
                            end
                    if (pos < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        busy[pos] = 1;
                        stored[pos] = op.value;
                        order[occ] = pos[5:0];
                        occ++;
                        r.new_handle = pos[5:0];
                    end
                end
                K_POP: begin
                    if (occ == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.payload = stored[order[0]];
                        busy[order[0]] = 0;
                        for (int i = 1; i < occ; i++) order[i-1] = order[i];
                        occ--;
                    end
                end
                default: begin
                    pos = busy[op.handle] ? place_of(op.handle) : -1;
                    if (pos < 0) begin
                        r.status = ST_NOREF;
                    end else if (op.kind == K_QUERY) begin
                        r.place = pos[5:0];
                    end else begin
                        tgt = (op.jump_len > pos) ? 0 : pos - op.jump_len;
                        for (int i = pos; i > tgt; i--) order[i] = order[i-1];
                        order[tgt] = op.handle;
                        r.place = tgt[5:0];
                    end
                end
            endcase
            r.count = occ[6:0];
            awaited = {awaited, r};
        endfunction

        function void check_result(res_t got);
            res_t e;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited");
                errors++;
                return;
            end
            e = awaited.pop_front();
            n_checked++;
            n_status[e.status]++;
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.payload !== e.payload) begin
                $error("payload: expected %h, got %h", e.payload, got.payload);
                errors++;
            end
            if (got.new_handle !== e.new_handle) begin
                $error("new_handle: expected %0d, got %0d", e.new_handle, got.new_handle);
                errors++;
            end
            if (got.place !== e.place) begin
                $error("place: expected %0d, got %0d", e.place, got.place);
                errors++;
            end
            if (got.count !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_value = '0;
    logic [5:0]  i_handle = '0;
    logic [15:0] i_jump_distance = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_payload;
    logic [5:0]  o_new_handle;
    logic [5:0]  o_place;
    logic [6:0]  o_entry_count;

    queue_with_jump_ahead_unit i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    queue_scoreboard sb = new();

    // Idle percentages, changed per phase by the stimulus process
    int  send_idle_pct = 21;
    int  recv_idle_pct = 61;
    bit  hold_off = 0;      // long receiver stall requested
    bit  stim_done = 0;
    int  idle_cycles = 0;
    int  n_sent = 0;
    int  n_jumps_clamped = 0;

    // Mirror of the handles believed queued, to aim queries and jumps
    function automatic logic [5:0] pick_handle();
        int tries;
        logic [5:0] h;
        for (tries = 0; tries < 8; tries++) begin
            h = 6'($urandom_range(0, QDEPTH-1));
            if (sb.busy[h]) return h;
        end
        return h;
    endfunction

    // Offer one beat; valid held until accepted, dropped only while idling
    task automatic send_beat(op_t op);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= op.kind;
        i_value <= op.value;
        i_handle <= op.handle;
        i_jump_distance <= op.jump_len;
        @(posedge i_clk);
        while (!(o_ready === 1'b1)) @(posedge i_clk);
        sb.note_op(op);
        n_sent++;
        if (op.kind == K_JUMP && op.jump_len > QDEPTH) n_jumps_clamped++;
        @(negedge i_clk);
    endtask

    function automatic op_t make_op(t_kind k, logic [31:0] v, logic [5:0] h, logic [15:0] d);
        op_t op;
        op.kind = k;
        op.value = v;
        op.handle = h;
        op.jump_len = d;
        return op;
    endfunction

    // Random operation, biased by fill so the queue swings between empty and full
    function automatic op_t rand_op(int fill_bias);
        int   r;
        op_t  op;
        r = $urandom_range(0, 99);
        op.value = $urandom();
        op.handle = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : pick_handle();
        case ($urandom_range(0, 3))
            0: op.jump_len = 16'($urandom());
            1: op.jump_len = 16'($urandom_range(0, 3));
            default: op.jump_len = 16'($urandom_range(0, 70));
        endcase
        if (r < fill_bias) op.kind = K_PUSH;
        else if (r < fill_bias + 25) op.kind = K_POP;
        else if (r < fill_bias + 45) op.kind = K_QUERY;
        else op.kind = K_JUMP;
        return op;
    endfunction

    task automatic random_phase(int n);
        int bias;
        for (int i = 0; i < n; i++) begin
            // slow swing of push bias between draining and filling
            bias = ((i / 120) % 2) ? 15 : 45;
            send_beat(rand_op(bias));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        sb.clear();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty cases, fill to full, edge values, jumps
        send_beat(make_op(K_POP, 32'h0, 6'd0, 16'd0));
        send_beat(make_op(K_QUERY, 32'h0, 6'd0, 16'd0));
        send_beat(make_op(K_JUMP, 32'h0, 6'd63, 16'hFFFF));
        send_beat(make_op(K_PUSH, 32'hFFFF_FFFF, 6'd0, 16'd0));
        send_beat(make_op(K_PUSH, 32'h0000_0000, 6'd63, 16'hFFFF));
        send_beat(make_op(K_PUSH, 32'hA5A5_5A5A, 6'd0, 16'd0));
        send_beat(make_op(K_QUERY, 32'h0, 6'd2, 16'd0));
        send_beat(make_op(K_JUMP, 32'h0, 6'd2, 16'd0));      // distance zero
        send_beat(make_op(K_JUMP, 32'h0, 6'd2, 16'd1));
        send_beat(make_op(K_JUMP, 32'h0, 6'd0, 16'hFFFF));   // clamped to head
        send_beat(make_op(K_QUERY, 32'h0, 6'd5, 16'd0));     // never queued
        send_beat(make_op(K_POP, 32'h0, 6'd0, 16'd0));
        send_beat(make_op(K_JUMP, 32'h0, 6'd1, 16'd1));      // queued handle moved up one
        for (int i = 0; i < 66; i++)                         // fill, then full a few times
            send_beat(make_op(K_PUSH, $urandom(), 6'($urandom()), 16'($urandom())));
        send_beat(make_op(K_JUMP, 32'h0, 6'd63, 16'd63));
        send_beat(make_op(K_QUERY, 32'h0, 6'd63, 16'd0));
        send_beat(make_op(K_JUMP, 32'h0, 6'd63, 16'hFFFF));
        wait_drained();

        // Long receiver stall while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(20);
        join

        random_phase(480);
        send_idle_pct = 61;
        recv_idle_pct = 21;
        random_phase(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(480);
        wait_drained();
        stim_done = 1;
    end

    // Receiver: ready toggles at random; results sampled at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            sb.check_result('{t_status'(o_status), o_payload, o_new_handle,
                              o_place, o_entry_count});
    end

    // Watchdog on cycles with no beat moving either way; also the end of run
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress, %0d results outstanding", sb.awaited.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        repeat (10) @(posedge i_clk);
        if (sb.awaited.size() != 0) begin
            $error("%0d results never arrived", sb.awaited.size());
            sb.errors++;
        end
        $display("covered %0d operations, %0d results checked: ok %0d, empty %0d, full %0d, bad handle %0d",
                 n_sent, sb.n_checked, sb.n_status[ST_OK], sb.n_status[ST_EMPTY],
                 sb.n_status[ST_FULL], sb.n_status[ST_NOREF]);
        $display("clamped long jumps %0d, with sender/receiver idling and one long stall",
                 n_jumps_clamped);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
